// ----- rtl/core/gpc_pkg.sv -----
// Shared types and constants for the Goldbach prime-count core.
// Used by gpc_ctrl, gpc_datapath, goldbach_prime_count_core and gpc_checker.
// No dependencies.
package gpc_pkg;

  // Width of the tested value and of the serial divider
  localparam int unsigned NUMBER_WIDTH   = 32;
  localparam int unsigned IN_DATA_WIDTH  = ((NUMBER_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_WIDTH = 8;
  localparam int unsigned STEP_WIDTH     = $clog2(NUMBER_WIDTH);

  typedef logic [NUMBER_WIDTH-1:0] number_t;
  typedef logic [STEP_WIDTH-1:0]   step_t;
  typedef logic [1:0]              count_t;

  // Result codes
  localparam count_t COUNT_ONE   = 2'd1;
  localparam count_t COUNT_TWO   = 2'd2;
  localparam count_t COUNT_THREE = 2'd3;

  // First trial divisor and last divider step
  localparam number_t FIRST_DIVISOR = number_t'(2);
  localparam step_t   LAST_STEP     = step_t'(NUMBER_WIDTH - 1);

  // Which value a primality test runs on
  typedef enum logic {
    SRC_INPUT,
    SRC_MINUS_TWO
  } src_t;

  // Controller to datapath
  typedef struct packed {
    logic   start;  // load tested value, divisor 2, start a division
    src_t   src;    // tested value source for start
    logic   step;   // one restoring-division step
    logic   next;   // advance divisor and restart the division
    logic   put;    // load the output word
    count_t code;   // result for put
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;    // division is on its last step
    logic no_divisor;  // divisor exceeds quotient: loop bound passed
    logic rem_zero;    // remainder is zero
    logic even;        // input value is even
  } dp_status_t;

endpackage

// ----- rtl/core/gpc_datapath.sv -----
// Datapath of the Goldbach prime-count core: value registers, trial divisor
// and a bit-serial restoring divider giving quotient and remainder.
// Depends on gpc_pkg.
module gpc_datapath (
  input  logic                                clk,
  input  logic [gpc_pkg::IN_DATA_WIDTH-1:0]   in_data,
  input  gpc_pkg::dp_cmd_t                    cmd,
  output gpc_pkg::dp_status_t                 status,
  output logic [gpc_pkg::OUT_DATA_WIDTH-1:0]  out_data
);

  gpc_pkg::number_t in_number;
  gpc_pkg::number_t value;
  gpc_pkg::number_t tested;
  gpc_pkg::number_t divisor;
  gpc_pkg::number_t rem;
  gpc_pkg::number_t quo;
  gpc_pkg::step_t   step_cnt;
  gpc_pkg::count_t  result;

  gpc_pkg::number_t              start_value;
  logic [gpc_pkg::NUMBER_WIDTH:0] shifted;
  logic [gpc_pkg::NUMBER_WIDTH:0] diff;
  logic                          fits;
  gpc_pkg::number_t              rem_next;
  gpc_pkg::number_t              quo_next;

  assign in_number = in_data[gpc_pkg::NUMBER_WIDTH-1:0];

  // Pick the value to test: the input word, or the held value minus two
  assign start_value = (cmd.src == gpc_pkg::SRC_INPUT) ? in_number
                                                       : value - gpc_pkg::FIRST_DIVISOR;

  // One restoring-division step: shift in the next dividend bit, subtract if it fits
  assign shifted  = {rem, quo[gpc_pkg::NUMBER_WIDTH-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign fits     = ~diff[gpc_pkg::NUMBER_WIDTH];
  assign rem_next = fits ? diff[gpc_pkg::NUMBER_WIDTH-1:0]
                         : shifted[gpc_pkg::NUMBER_WIDTH-1:0];
  assign quo_next = {quo[gpc_pkg::NUMBER_WIDTH-2:0], fits};

  // Hold the value, run the divider, advance the divisor
  always_ff @(posedge clk) begin
    if (cmd.start && cmd.src == gpc_pkg::SRC_INPUT) begin
      value <= in_number;
    end
    if (cmd.start) begin
      tested   <= start_value;
      divisor  <= gpc_pkg::FIRST_DIVISOR;
      rem      <= '0;
      quo      <= start_value;
      step_cnt <= '0;
    end else if (cmd.next) begin
      divisor  <= divisor + gpc_pkg::number_t'(1);
      rem      <= '0;
      quo      <= tested;
      step_cnt <= '0;
    end else if (cmd.step) begin
      rem      <= rem_next;
      quo      <= quo_next;
      step_cnt <= step_cnt + gpc_pkg::step_t'(1);
    end
    if (cmd.put) begin
      result <= cmd.code;
    end
  end

  // Report the last divider step, loop bound, remainder and parity
  assign status.div_last   = (step_cnt == gpc_pkg::LAST_STEP);
  assign status.no_divisor = (divisor > quo);
  assign status.rem_zero   = (rem == '0);
  assign status.even       = ~value[0];

  assign out_data = gpc_pkg::OUT_DATA_WIDTH'(result);

endmodule

// ----- rtl/core/gpc_ctrl.sv -----
// Controller of the Goldbach prime-count core: sequences the trial-division
// tests, decides the result and owns both stream handshakes.
// Depends on gpc_pkg.
module gpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  gpc_pkg::dp_status_t status,
  output gpc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_HOLD
  } state_t;

  state_t          state, state_next;
  gpc_pkg::src_t   phase, phase_next;
  gpc_pkg::count_t pending, pending_next;
  logic            m_tvalid_next;
  logic            out_free;
  logic            finish;
  gpc_pkg::count_t finish_code;

  assign s_tready = (state == S_IDLE);
  assign out_free = ~m_tvalid | m_tready;

  // Decide commands and the next state
  always_comb begin
    cmd          = '0;
    cmd.src      = gpc_pkg::SRC_INPUT;
    state_next   = state;
    phase_next   = phase;
    pending_next = pending;
    finish       = 1'b0;
    finish_code  = gpc_pkg::COUNT_ONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          cmd.src    = gpc_pkg::SRC_INPUT;
          phase_next = gpc_pkg::SRC_INPUT;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.no_divisor) begin
          // no divisor up to the square root: tested value is prime
          finish      = 1'b1;
          finish_code = (phase == gpc_pkg::SRC_INPUT) ? gpc_pkg::COUNT_ONE
                                                      : gpc_pkg::COUNT_TWO;
        end else if (status.rem_zero) begin
          if (phase == gpc_pkg::SRC_INPUT && !status.even) begin
            // odd composite: test value minus two next
            cmd.start  = 1'b1;
            cmd.src    = gpc_pkg::SRC_MINUS_TWO;
            phase_next = gpc_pkg::SRC_MINUS_TWO;
            state_next = S_DIV;
          end else begin
            finish      = 1'b1;
            finish_code = status.even ? gpc_pkg::COUNT_TWO : gpc_pkg::COUNT_THREE;
          end
        end else begin
          cmd.next   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.put    = 1'b1;
          cmd.code   = pending;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Deliver the result now if the output word is free, else park it
    if (finish) begin
      pending_next = finish_code;
      if (out_free) begin
        cmd.put    = 1'b1;
        cmd.code   = finish_code;
        state_next = S_IDLE;
      end else begin
        state_next = S_HOLD;
      end
    end

    m_tvalid_next = cmd.put | (m_tvalid & ~m_tready);
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= gpc_pkg::SRC_INPUT;
      pending  <= gpc_pkg::COUNT_ONE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      pending  <= pending_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ----- rtl/core/goldbach_prime_count_core.sv -----
// Top level of the Goldbach prime-count core: joins controller and datapath.
// Depends on gpc_pkg, gpc_ctrl and gpc_datapath.
// Each trial divisor takes a full serial division and a check; a test of
// value v runs about sqrt(v) divisors, and up to two tests run per word.
// Throughput: one word at a time; the next is taken once the result is loaded.
// Reset: synchronous, active high; clears the sequencer and output valid.
module goldbach_prime_count_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: [31:0] number
  input  logic [gpc_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: [1:0] prime_count, [7:2] zero
  output logic [gpc_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);

  gpc_pkg::dp_cmd_t    cmd;
  gpc_pkg::dp_status_t status;

  gpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gpc_datapath u_datapath (
    .clk      (clk),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_tdata)
  );

endmodule

// ----- rtl/core/gpc_checker.sv -----
// Port-level checks for goldbach_prime_count_core, bound to the top level.
// Depends on gpc_pkg and goldbach_prime_count_core.
module gpc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [gpc_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [gpc_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A result is 1, 2 or 3 with zero padding
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd0) && (m_tdata[7:2] == 6'd0))
    else $error("result out of range");

  // An accepted word keeps the core busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !(m_tvalid && $rose(m_tvalid)))
    else $error("core not busy after accepting a word");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Idle ready is not lost without a word being taken
  a_ready_kept: assert property (@(posedge clk) disable iff (rst)
    s_tready && !s_tvalid |=> s_tready)
    else $error("ready dropped without an accepted word");

endmodule

bind goldbach_prime_count_core gpc_checker u_gpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
